FILE: rtl/core/tmq_pkg.sv
// shared types and constants of the typed message queue engine
`default_nettype none
package tmq_pkg;

  localparam int NUM_QUEUES  = 16;
  localparam int POOL_SLOTS  = 256;
  localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOT_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W       = $clog2(POOL_SLOTS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [19:0] DEF_LIMIT_RESET = 20'd16384;
  localparam logic [15:0] MAX_BYTES_RESET = 16'd8192;
  localparam logic [8:0]  MODE_MASK       = 9'h1FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_LIMIT = 2'd0,
    CFG_MAX_BYTES     = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_GET     = 3'd0,
    OP_STAT    = 3'd1,
    OP_SET     = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_SEND    = 3'd4,
    OP_RECEIVE = 3'd5
  } opcode_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_BADQ     = 4'd1,
    ST_NOKEY    = 4'd2,
    ST_NOQ      = 4'd3,
    ST_BADSIZE  = 4'd4,
    ST_FULL     = 4'd5,
    ST_FULLWB   = 4'd6,
    ST_POOL     = 4'd7,
    ST_EMPTY    = 4'd8,
    ST_EMPTYWB  = 4'd9,
    ST_TOOLARGE = 4'd10,
    ST_UNKNOWN  = 4'd11
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RM_RD, S_RM_WT, S_SCAN, S_TAIL_RD, S_TAIL_WT,
    S_RV_RD, S_RV_WT, S_RV_DONE, S_PREV_RD, S_PREV_WT, S_WB, S_FIN
  } state_t;

  typedef struct packed {
    logic              active;
    logic [31:0]       key;
    logic [8:0]        mode;
    logic [CNT_W-1:0]  count;
    logic [19:0]       bytes;
    logic [19:0]       limit;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [14:0]       sender;
    logic [14:0]       receiver;
  } queue_rec_t;

  localparam queue_rec_t REC_RESET = '{
    active: 1'b0, key: '0, mode: '0, count: '0, bytes: '0,
    limit: DEF_LIMIT_RESET, head: '0, tail: '0, sender: '0, receiver: '0
  };

  typedef struct packed {
    logic              en;
    logic [QIDX_W-1:0] idx;
    queue_rec_t        rec;
  } cell_wr_t;

  typedef struct packed {
    logic key_hit;
    logic free_hit;
  } link_t;

  typedef struct packed {
    logic [SLOT_W-1:0] next;
    logic [31:0]       mtype;
    logic [15:0]       size;
    logic [31:0]       handle;
  } slot_ent_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  result_queue;
    logic [31:0] got_type;
    logic [15:0] got_size;
    logic [31:0] got_handle;
    logic [8:0]  message_count;
    logic [19:0] byte_count;
    logic [19:0] byte_limit;
    logic [8:0]  mode_out;
    logic [14:0] last_sender;
    logic [14:0] last_receiver;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/typed_message_queue_engine.sv
// typed message queue engine top level: queue cell row, descriptor ram and sequencer
//
// Input channel (in_*): one operation per beat, taken only while the sequencer is idle.
// Result channel (out_*): exactly one result beat per operation, held in an output
// register; the next operation is taken while a result still waits, and its result
// waits in turn until the previous one has been taken.
// Config port (cfg_*): always ready; index 0 default queue limit, 1 max message bytes,
// other indexes are ignored. Write only while no operation is in flight.
// Unknown op, get, stat, set, bad queue and bad size finish straight after decode;
// remove and receive walk every queued message, and a receive that takes a message
// other than the first one also rewrites the link of the message before it. Send
// searches the descriptors for the lowest free one, one slot per cycle, and links the
// new message behind the tail when the queue already holds messages.
// The next operation can be taken in the cycle after the previous result beat is loaded.
// List walks go through the single descriptor ram read port.
// Reset clears the queue table and all descriptor in-use flags at once; the
// descriptor ram needs no clearing pass. A stalled receiver holds the result beat
// and, after one further operation, the input channel.
`default_nettype none
module typed_message_queue_engine
  import tmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic signed [31:0]    in_queue_key,
  input  logic                  in_create,
  input  logic [8:0]            in_mode_bits,
  input  logic [7:0]            in_queue_id,
  input  logic signed [31:0]    in_msg_type,
  input  logic [15:0]           in_size,
  input  logic [19:0]           in_new_limit,
  input  logic                  in_nowait,
  input  logic [14:0]           in_caller_pid,
  input  logic [31:0]           in_payload_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_status,
  output logic [7:0]            out_result_queue,
  output logic signed [31:0]    out_got_type,
  output logic [15:0]           out_got_size,
  output logic [31:0]           out_got_handle,
  output logic [8:0]            out_message_count,
  output logic [19:0]           out_byte_count,
  output logic [19:0]           out_byte_limit,
  output logic [8:0]            out_mode_out,
  output logic [14:0]           out_last_sender,
  output logic [14:0]           out_last_receiver,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [19:0] dflt_limit_r;
  logic [15:0] max_bytes_r;

  logic [2:0]        op_r, op_nxt;
  logic [31:0]       key_r, key_nxt;
  logic              create_r, create_nxt;
  logic [8:0]        mode_r, mode_nxt;
  logic [7:0]        qid_r, qid_nxt;
  logic [31:0]       mtype_r, mtype_nxt;
  logic [15:0]       size_r, size_nxt;
  logic [19:0]       nlimit_r, nlimit_nxt;
  logic              nowait_r, nowait_nxt;
  logic [14:0]       pid_r, pid_nxt;
  logic [31:0]       handle_r, handle_nxt;

  queue_rec_t        rec_r, rec_nxt;
  logic [QIDX_W-1:0] qi_r, qi_nxt;
  result_t           res_r, res_nxt;
  result_t           outq_r, outq_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SLOT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [SLOT_W-1:0] prev_r, prev_nxt;
  logic              first_r, first_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       best_r, best_nxt;
  logic [SLOT_W-1:0] pick_r, pick_nxt;
  logic [SLOT_W-1:0] pickprev_r, pickprev_nxt;
  logic              pickfirst_r, pickfirst_nxt;
  slot_ent_t         pent_r, pent_nxt;

  logic [POOL_SLOTS-1:0] used_r, used_nxt;

  cell_wr_t          cell_wr;
  queue_rec_t        cell_rec [NUM_QUEUES];
  link_t             chain [NUM_QUEUES+1];
  link_t             first_hit [NUM_QUEUES];
  logic [QIDX_W-1:0] hit_idx;
  logic [QIDX_W-1:0] free_idx;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_ent_t         ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  slot_ent_t         ram_rdata;
  logic [$bits(slot_ent_t)-1:0] ram_rbits;

  queue_rec_t        sel_rec;
  logic              q_ok;
  logic [20:0]       bytes_sum;
  logic signed [32:0] recv_lim;
  logic signed [32:0] t_ext;
  logic              take;
  logic              in_acc;

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_cell
    tmq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (QIDX_W'(g)),
      .wr         (cell_wr),
      .search_key (key_r),
      .chain_in   (chain[g]),
      .chain_out  (chain[g+1]),
      .first_out  (first_hit[g]),
      .rec        (cell_rec[g])
    );
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (first_hit[i].key_hit) begin
        hit_idx = hit_idx | QIDX_W'(i);
      end
      if (first_hit[i].free_hit) begin
        free_idx = free_idx | QIDX_W'(i);
      end
    end
  end

  tmq_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (POOL_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = slot_ent_t'(ram_rbits);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign sel_rec   = cell_rec[qid_r[QIDX_W-1:0]];
  assign q_ok      = ({1'b0, qid_r} < 9'(NUM_QUEUES)) && sel_rec.active;
  assign bytes_sum = {1'b0, rec_r.bytes} + 21'(size_r);
  assign recv_lim  = -$signed({mtype_r[31], mtype_r});
  assign t_ext     = $signed({ram_rdata.mtype[31], ram_rdata.mtype});

  always_comb begin
    take = 1'b0;
    if (mtype_r == '0) begin
      take = !found_r;
    end else if (!mtype_r[31]) begin
      take = !found_r && (ram_rdata.mtype == mtype_r);
    end else begin
      take = (t_ext <= recv_lim) &&
             (!found_r || ($signed(ram_rdata.mtype) < $signed(best_r)));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    create_nxt    = create_r;
    mode_nxt      = mode_r;
    qid_nxt       = qid_r;
    mtype_nxt     = mtype_r;
    size_nxt      = size_r;
    nlimit_nxt    = nlimit_r;
    nowait_nxt    = nowait_r;
    pid_nxt       = pid_r;
    handle_nxt    = handle_r;
    rec_nxt       = rec_r;
    qi_nxt        = qi_r;
    res_nxt       = res_r;
    outq_nxt      = outq_r;
    out_valid_nxt = out_valid_r;
    n_nxt         = n_r;
    left_nxt      = left_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    pickprev_nxt  = pickprev_r;
    pickfirst_nxt = pickfirst_r;
    pent_nxt      = pent_r;
    used_nxt      = used_r;
    cell_wr       = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_opcode;
          key_nxt    = in_queue_key;
          create_nxt = in_create;
          mode_nxt   = in_mode_bits & MODE_MASK;
          qid_nxt    = in_queue_id;
          mtype_nxt  = in_msg_type;
          size_nxt   = in_size;
          nlimit_nxt = in_new_limit;
          nowait_nxt = in_nowait;
          pid_nxt    = in_caller_pid;
          handle_nxt = in_payload_handle;
          res_nxt    = '0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        rec_nxt   = sel_rec;
        qi_nxt    = qid_r[QIDX_W-1:0];
        state_nxt = S_FIN;
        if (op_r > 3'(OP_RECEIVE)) begin
          res_nxt.status = ST_UNKNOWN;
        end else if (op_r == 3'(OP_GET)) begin
          if (chain[NUM_QUEUES].key_hit) begin
            res_nxt.status       = ST_OK;
            res_nxt.result_queue = 8'(hit_idx);
          end else if (!create_r) begin
            res_nxt.status = ST_NOKEY;
          end else if (chain[NUM_QUEUES].free_hit) begin
            cell_wr.en           = 1'b1;
            cell_wr.idx          = free_idx;
            cell_wr.rec          = REC_RESET;
            cell_wr.rec.limit    = dflt_limit_r;
            cell_wr.rec.active   = 1'b1;
            cell_wr.rec.key      = key_r;
            cell_wr.rec.mode     = mode_r;
            res_nxt.status       = ST_OK;
            res_nxt.result_queue = 8'(free_idx);
          end else begin
            res_nxt.status = ST_NOQ;
          end
        end else if (!q_ok) begin
          res_nxt.status = ST_BADQ;
        end else begin
          unique case (op_r)
            3'(OP_STAT): begin
              res_nxt.status        = ST_OK;
              res_nxt.message_count = (16'(sel_rec.count) > 16'd511) ? 9'h1FF
                                                                    : 9'(sel_rec.count);
              res_nxt.byte_count    = sel_rec.bytes;
              res_nxt.byte_limit    = sel_rec.limit;
              res_nxt.mode_out      = sel_rec.mode;
              res_nxt.last_sender   = sel_rec.sender;
              res_nxt.last_receiver = sel_rec.receiver;
            end
            3'(OP_SET): begin
              cell_wr.en         = 1'b1;
              cell_wr.idx        = qid_r[QIDX_W-1:0];
              cell_wr.rec        = sel_rec;
              cell_wr.rec.mode   = mode_r;
              cell_wr.rec.limit  = nlimit_r;
              res_nxt.status     = ST_OK;
            end
            3'(OP_REMOVE): begin
              n_nxt     = sel_rec.head;
              left_nxt  = sel_rec.count;
              state_nxt = S_RM_RD;
            end
            3'(OP_SEND): begin
              pick_nxt = '0;
              if ((size_r == '0) || (size_r > max_bytes_r)) begin
                res_nxt.status = ST_BADSIZE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              n_nxt     = sel_rec.head;
              left_nxt  = sel_rec.count;
              prev_nxt  = '0;
              first_nxt = 1'b1;
              found_nxt = 1'b0;
              best_nxt  = '0;
              state_nxt = S_RV_RD;
            end
          endcase
        end
      end
      S_RM_RD: begin
        if (left_r == '0) begin
          rec_nxt       = REC_RESET;
          rec_nxt.limit = dflt_limit_r;
          res_nxt.status = ST_OK;
          state_nxt     = S_WB;
        end else begin
          ram_raddr        = n_r;
          used_nxt[n_r]    = 1'b0;
          state_nxt        = S_RM_WT;
        end
      end
      S_RM_WT: begin
        n_nxt     = ram_rdata.next;
        left_nxt  = left_r - 1'b1;
        state_nxt = S_RM_RD;
      end
      S_SCAN: begin
        if (bytes_sum > {1'b0, rec_r.limit}) begin
          res_nxt.status = nowait_r ? ST_FULL : ST_FULLWB;
          state_nxt      = S_FIN;
        end else if (!used_r[pick_r]) begin
          used_nxt[pick_r] = 1'b1;
          ram_we           = 1'b1;
          ram_waddr        = pick_r;
          ram_wdata.next   = '0;
          ram_wdata.mtype  = mtype_r;
          ram_wdata.size   = size_r;
          ram_wdata.handle = handle_r;
          prev_nxt         = rec_r.tail;
          if (rec_r.count == '0) begin
            rec_nxt.head = pick_r;
            state_nxt    = S_WB;
          end else begin
            state_nxt = S_TAIL_RD;
          end
          rec_nxt.tail     = pick_r;
          rec_nxt.count    = rec_r.count + 1'b1;
          rec_nxt.bytes    = bytes_sum[19:0];
          rec_nxt.sender   = pid_r;
          res_nxt.status   = ST_OK;
          res_nxt.got_size = size_r;
        end else if (pick_r == SLOT_W'(POOL_SLOTS - 1)) begin
          res_nxt.status = ST_POOL;
          state_nxt      = S_FIN;
        end else begin
          pick_nxt = pick_r + 1'b1;
        end
      end
      S_TAIL_RD: begin
        ram_raddr = prev_r;
        state_nxt = S_TAIL_WT;
      end
      S_TAIL_WT: begin
        ram_we         = 1'b1;
        ram_waddr      = prev_r;
        ram_wdata      = ram_rdata;
        ram_wdata.next = pick_r;
        state_nxt      = S_WB;
      end
      S_RV_RD: begin
        if (left_r == '0) begin
          state_nxt = S_RV_DONE;
        end else begin
          ram_raddr = n_r;
          state_nxt = S_RV_WT;
        end
      end
      S_RV_WT: begin
        if (take) begin
          found_nxt     = 1'b1;
          best_nxt      = ram_rdata.mtype;
          pick_nxt      = n_r;
          pickprev_nxt  = prev_r;
          pickfirst_nxt = first_r;
          pent_nxt      = ram_rdata;
        end
        prev_nxt  = n_r;
        first_nxt = 1'b0;
        n_nxt     = ram_rdata.next;
        left_nxt  = left_r - 1'b1;
        state_nxt = S_RV_RD;
      end
      S_RV_DONE: begin
        state_nxt = S_FIN;
        if (!found_r) begin
          res_nxt.status = nowait_r ? ST_EMPTY : ST_EMPTYWB;
        end else if (pent_r.size > size_r) begin
          res_nxt.status   = ST_TOOLARGE;
          res_nxt.got_size = pent_r.size;
        end else begin
          res_nxt.status     = ST_OK;
          res_nxt.got_type   = pent_r.mtype;
          res_nxt.got_size   = pent_r.size;
          res_nxt.got_handle = pent_r.handle;
          used_nxt[pick_r]   = 1'b0;
          if (pickfirst_r) begin
            rec_nxt.head = pent_r.next;
          end
          if (rec_r.tail == pick_r) begin
            rec_nxt.tail = pickfirst_r ? '0 : pickprev_r;
          end
          rec_nxt.count    = rec_r.count - 1'b1;
          rec_nxt.bytes    = rec_r.bytes - 20'(pent_r.size);
          rec_nxt.receiver = pid_r;
          state_nxt        = pickfirst_r ? S_WB : S_PREV_RD;
        end
      end
      S_PREV_RD: begin
        ram_raddr = pickprev_r;
        state_nxt = S_PREV_WT;
      end
      S_PREV_WT: begin
        ram_we         = 1'b1;
        ram_waddr      = pickprev_r;
        ram_wdata      = ram_rdata;
        ram_wdata.next = pent_r.next;
        state_nxt      = S_WB;
      end
      S_WB: begin
        cell_wr.en  = 1'b1;
        cell_wr.idx = qi_r;
        cell_wr.rec = rec_r;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          outq_nxt      = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      dflt_limit_r <= DEF_LIMIT_RESET;
      max_bytes_r  <= MAX_BYTES_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEFAULT_LIMIT) begin
          dflt_limit_r <= cfg_data[19:0];
        end else if (cfg_index == CFG_MAX_BYTES) begin
          max_bytes_r <= cfg_data[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    create_r    <= create_nxt;
    mode_r      <= mode_nxt;
    qid_r       <= qid_nxt;
    mtype_r     <= mtype_nxt;
    size_r      <= size_nxt;
    nlimit_r    <= nlimit_nxt;
    nowait_r    <= nowait_nxt;
    pid_r       <= pid_nxt;
    handle_r    <= handle_nxt;
    rec_r       <= rec_nxt;
    qi_r        <= qi_nxt;
    res_r       <= res_nxt;
    outq_r      <= outq_nxt;
    n_r         <= n_nxt;
    left_r      <= left_nxt;
    prev_r      <= prev_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
    pickprev_r  <= pickprev_nxt;
    pickfirst_r <= pickfirst_nxt;
    pent_r      <= pent_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = outq_r.status;
  assign out_result_queue  = outq_r.result_queue;
  assign out_got_type      = outq_r.got_type;
  assign out_got_size      = outq_r.got_size;
  assign out_got_handle    = outq_r.got_handle;
  assign out_message_count = outq_r.message_count;
  assign out_byte_count    = outq_r.byte_count;
  assign out_byte_limit    = outq_r.byte_limit;
  assign out_mode_out      = outq_r.mode_out;
  assign out_last_sender   = outq_r.last_sender;
  assign out_last_receiver = outq_r.last_receiver;

endmodule
`default_nettype wire

FILE: rtl/core/tmq_ram.sv
// generic single write port ram with registered read
`default_nettype none
module tmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/tmq_cell.sv
// one queue table cell: holds a queue record and forms the key and free search chain
`default_nettype none
module tmq_cell
  import tmq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [QIDX_W-1:0] cell_idx,
  input  cell_wr_t          wr,
  input  logic [31:0]       search_key,
  input  link_t             chain_in,
  output link_t             chain_out,
  output link_t             first_out,
  output queue_rec_t        rec
);

  queue_rec_t rec_r;
  queue_rec_t rec_nxt;
  logic       key_hit;
  logic       free_hit;

  always_comb begin
    rec_nxt = rec_r;
    if (wr.en && (wr.idx == cell_idx)) begin
      rec_nxt = wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= REC_RESET;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign key_hit            = rec_r.active && (rec_r.key == search_key);
  assign free_hit           = !rec_r.active;
  assign chain_out.key_hit  = chain_in.key_hit | key_hit;
  assign chain_out.free_hit = chain_in.free_hit | free_hit;
  assign first_out.key_hit  = key_hit & !chain_in.key_hit;
  assign first_out.free_hit = free_hit & !chain_in.free_hit;
  assign rec                = rec_r;

endmodule
`default_nettype wire

FILE: rtl/core/tmq_checker.sv
// port level checker of the typed message queue engine and its bind
`default_nettype none
module tmq_checker
  import tmq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [3:0]            out_status,
  input logic signed [31:0]    out_got_type,
  input logic [31:0]           out_got_handle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_got_handle))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second operation taken while one is in flight");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 4'(ST_UNKNOWN))
    else $error("status code out of range");

  a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 4'(ST_OK)) |-> (out_got_handle == '0) && (out_got_type == '0))
    else $error("failed operation carries message fields");

endmodule

bind typed_message_queue_engine tmq_checker u_tmq_checker (.*);
`default_nettype wire

FILE: test/tb.sv
// testbench of the typed message queue engine: directed and random operations against a predictor
`timescale 1ns / 100ps
module tb;
  import tmq_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  opcode;
    logic [31:0] queue_key;
    logic        create;
    logic [8:0]  mode_bits;
    logic [7:0]  queue_id;
    logic [31:0] msg_type;
    logic [15:0] size;
    logic [19:0] new_limit;
    logic        nowait;
    logic [14:0] caller_pid;
    logic [31:0] payload_handle;
  } op_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic signed [31:0] in_queue_key = '0;
  logic in_create = 1'b0;
  logic [8:0] in_mode_bits = '0;
  logic [7:0] in_queue_id = '0;
  logic signed [31:0] in_msg_type = '0;
  logic [15:0] in_size = '0;
  logic [19:0] in_new_limit = '0;
  logic in_nowait = 1'b0;
  logic [14:0] in_caller_pid = '0;
  logic [31:0] in_payload_handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_status;
  logic [7:0] out_result_queue;
  logic signed [31:0] out_got_type;
  logic [15:0] out_got_size;
  logic [31:0] out_got_handle;
  logic [8:0] out_message_count;
  logic [19:0] out_byte_count;
  logic [19:0] out_byte_limit;
  logic [8:0] out_mode_out;
  logic [14:0] out_last_sender;
  logic [14:0] out_last_receiver;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  typed_message_queue_engine dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  int unsigned new_queue_limit, max_send_bytes;
  bit          q_live[NUM_QUEUES];
  int unsigned q_key[NUM_QUEUES], q_mode[NUM_QUEUES], q_msgs[NUM_QUEUES];
  int unsigned q_bytes[NUM_QUEUES], q_limit[NUM_QUEUES];
  int unsigned q_head[NUM_QUEUES], q_tail[NUM_QUEUES];
  int unsigned q_sender[NUM_QUEUES], q_receiver[NUM_QUEUES];
  bit          d_busy[POOL_SLOTS];
  int unsigned d_next[POOL_SLOTS], d_type[POOL_SLOTS], d_size[POOL_SLOTS];
  int unsigned d_handle[POOL_SLOTS];

  op_beat_t pending_ops[$];
  result_t  awaited_results[$];
  op_beat_t cur;
  int send_idle = 0, recv_idle = 0, errors = 0, results_seen = 0;
  int status_seen[16];
  int key_pool[24];

  function automatic void wipe_queue(int unsigned q);
    q_live[q] = 0; q_key[q] = 0; q_mode[q] = 0; q_msgs[q] = 0; q_bytes[q] = 0;
    q_limit[q] = new_queue_limit; q_head[q] = 0; q_tail[q] = 0;
    q_sender[q] = 0; q_receiver[q] = 0;
  endfunction

  function automatic result_t run_op(op_beat_t b);
    result_t r;
    bit done;
    int unsigned q, s, n, prev, pick, pickprev, left;
    longint sel, lim, best, t;
    bit found, first, pickfirst, take;
    r = '0;
    r.status = ST_OK;
    q = b.queue_id;
    if (b.opcode == OP_SPARE_LO || b.opcode == OP_SPARE_HI) begin
      r.status = ST_UNKNOWN;
    end else if (b.opcode == OP_GET) begin
      done = 0;
      for (int i = 0; i < NUM_QUEUES && !done; i++)
        if (q_live[i] && q_key[i] == b.queue_key) begin
          r.result_queue = i; done = 1;
        end
      if (!done && !b.create) begin
        r.status = ST_NOKEY; done = 1;
      end
      for (int i = 0; i < NUM_QUEUES && !done; i++)
        if (!q_live[i]) begin
          wipe_queue(i);
          q_live[i] = 1; q_key[i] = b.queue_key; q_mode[i] = b.mode_bits;
          r.result_queue = i; done = 1;
        end
      if (!done) r.status = ST_NOQ;
    end else if (q >= NUM_QUEUES || !q_live[q]) begin
      r.status = ST_BADQ;
    end else if (b.opcode == OP_STAT) begin
      r.message_count = q_msgs[q] > 511 ? 511 : q_msgs[q];
      r.byte_count = q_bytes[q];
      r.byte_limit = q_limit[q];
      r.mode_out = q_mode[q];
      r.last_sender = q_sender[q];
      r.last_receiver = q_receiver[q];
    end else if (b.opcode == OP_SET) begin
      q_mode[q] = b.mode_bits;
      q_limit[q] = b.new_limit;
    end else if (b.opcode == OP_REMOVE) begin
      n = q_head[q];
      left = q_msgs[q];
      while (left > 0 && n < POOL_SLOTS) begin
        d_busy[n] = 0; n = d_next[n]; left--;
      end
      wipe_queue(q);
    end else if (b.opcode == OP_SEND) begin
      s = POOL_SLOTS;
      if (b.size == 0 || b.size > max_send_bytes) begin
        r.status = ST_BADSIZE;
      end else if (longint'(q_bytes[q]) + b.size > q_limit[q]) begin
        r.status = b.nowait ? ST_FULL : ST_FULLWB;
      end else begin
        for (int i = 0; i < POOL_SLOTS && s == POOL_SLOTS; i++)
          if (!d_busy[i]) s = i;
        if (s == POOL_SLOTS) begin
          r.status = ST_POOL;
        end else begin
          d_busy[s] = 1; d_type[s] = b.msg_type; d_size[s] = b.size;
          d_handle[s] = b.payload_handle; d_next[s] = 0;
          if (q_msgs[q] == 0) q_head[q] = s;
          else if (q_tail[q] < POOL_SLOTS) d_next[q_tail[q]] = s;
          q_tail[q] = s;
          q_msgs[q]++;
          q_bytes[q] += b.size;
          q_sender[q] = b.caller_pid;
          r.got_size = b.size;
        end
      end
    end else begin
      sel = longint'($signed(b.msg_type));
      lim = -sel;
      best = 0; found = 0; first = 1; pickfirst = 1;
      n = q_head[q]; prev = 0; pick = 0; pickprev = 0;
      left = q_msgs[q];
      while (left > 0 && n < POOL_SLOTS) begin
        t = longint'($signed(d_type[n]));
        if (sel == 0) take = !found;
        else if (sel > 0) take = !found && t == sel;
        else take = t <= lim && (!found || t < best);
        if (take) begin
          found = 1; best = t; pick = n; pickprev = prev; pickfirst = first;
        end
        prev = n; first = 0; n = d_next[n]; left--;
      end
      if (!found) begin
        r.status = b.nowait ? ST_EMPTY : ST_EMPTYWB;
      end else if (d_size[pick] > b.size) begin
        r.status = ST_TOOLARGE;
        r.got_size = d_size[pick];
      end else begin
        if (pickfirst) q_head[q] = d_next[pick];
        else d_next[pickprev] = d_next[pick];
        if (q_tail[q] == pick) q_tail[q] = pickfirst ? 0 : pickprev;
        q_msgs[q]--;
        q_bytes[q] -= d_size[pick];
        q_receiver[q] = b.caller_pid;
        d_busy[pick] = 0;
        r.got_type = d_type[pick];
        r.got_size = d_size[pick];
        r.got_handle = d_handle[pick];
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) awaited_results.push_back(run_op(cur));
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_opcode <= cur.opcode;
        in_queue_key <= cur.queue_key;
        in_create <= cur.create;
        in_mode_bits <= cur.mode_bits;
        in_queue_id <= cur.queue_id;
        in_msg_type <= cur.msg_type;
        in_size <= cur.size;
        in_new_limit <= cur.new_limit;
        in_nowait <= cur.nowait;
        in_caller_pid <= cur.caller_pid;
        in_payload_handle <= cur.payload_handle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no operation outstanding");
          errors++;
        end else begin
          e = awaited_results.pop_front();
          results_seen++;
          status_seen[e.status]++;
          check_field("status", e.status, out_status);
          check_field("result_queue", e.result_queue, out_result_queue);
          check_field("got_type", e.got_type, $unsigned(out_got_type));
          check_field("got_size", e.got_size, out_got_size);
          check_field("got_handle", e.got_handle, out_got_handle);
          check_field("message_count", e.message_count, out_message_count);
          check_field("byte_count", e.byte_count, out_byte_count);
          check_field("byte_limit", e.byte_limit, out_byte_limit);
          check_field("mode_out", e.mode_out, out_mode_out);
          check_field("last_sender", e.last_sender, out_last_sender);
          check_field("last_receiver", e.last_receiver, out_last_receiver);
        end
      end
    end
  end

  function automatic op_beat_t plain(logic [2:0] op, int unsigned qid);
    op_beat_t b;
    b = '{opcode: op, queue_key: 0, create: 0, mode_bits: 9'h1A4, queue_id: qid,
          msg_type: 0, size: 16'hFFFF, new_limit: 0, nowait: 1, caller_pid: 15'd100,
          payload_handle: 0};
    return b;
  endfunction

  function automatic op_beat_t random_op(int send_weight);
    op_beat_t b;
    int p;
    b.opcode = 0;
    b.queue_key = key_pool[$urandom_range(23)];
    b.create = $urandom_range(3) != 0;
    b.mode_bits = $urandom;
    b.queue_id = $urandom_range(19) == 0 ? $urandom_range(255) : $urandom_range(15);
    b.nowait = $urandom_range(1);
    b.caller_pid = $urandom;
    b.payload_handle = $urandom;
    b.new_limit = $urandom_range(2) == 0 ? $urandom_range(300) :
                  ($urandom_range(3) == 0 ? $urandom : 20'd20000);
    p = $urandom_range(99);
    if (p < 8) b.opcode = OP_GET;
    else if (p < 14) b.opcode = OP_STAT;
    else if (p < 17) b.opcode = OP_SET;
    else if (p < 19) b.opcode = OP_REMOVE;
    else if (p < 21) b.opcode = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
    else if (p < 21 + send_weight) b.opcode = OP_SEND;
    else b.opcode = OP_RECEIVE;
    if (b.opcode == OP_SEND) begin
      p = $urandom_range(19);
      b.msg_type = p < 16 ? $urandom_range(9) : (p < 18 ? -$urandom_range(9) : $urandom);
      p = $urandom_range(29);
      b.size = p == 0 ? 0 : (p == 1 ? $urandom : (p == 2 ? 16'hFFFF : $urandom_range(1, 64)));
    end else begin
      p = $urandom_range(19);
      if (p < 8) b.msg_type = 0;
      else if (p < 13) b.msg_type = $urandom_range(1, 9);
      else if (p < 18) b.msg_type = -$urandom_range(1, 9);
      else b.msg_type = $urandom_range(1) ? 32'h80000000 : $urandom;
      b.size = $urandom_range(9) == 0 ? $urandom_range(40) : 16'hFFFF;
    end
    return b;
  endfunction

  task automatic drain();
    do @(posedge clk); while (pending_ops.size() > 0 || in_valid || awaited_results.size() > 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEFAULT_LIMIT) new_queue_limit = value & 20'hFFFFF;
    else max_send_bytes = value & 16'hFFFF;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int tx_idle, int rx_idle, int send_weight);
    send_idle = tx_idle;
    recv_idle = rx_idle;
    for (int i = 0; i < n; i++) pending_ops.push_back(random_op(send_weight));
    drain();
  endtask

  initial begin
    op_beat_t b;
    new_queue_limit = DEF_LIMIT_RESET;
    max_send_bytes = MAX_BYTES_RESET;
    for (int i = 0; i < NUM_QUEUES; i++) wipe_queue(i);
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h80000000;
    key_pool[1] = 32'h7FFFFFFF;
    key_pool[2] = 0;
    key_pool[3] = -1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset register values
    pending_ops.push_back(plain(OP_SPARE_LO, 0));
    pending_ops.push_back(plain(OP_SPARE_HI, 0));
    pending_ops.push_back(plain(OP_STAT, 200));
    b = plain(OP_GET, 0); b.queue_key = 32'h80000000; pending_ops.push_back(b);
    b.create = 1; b.mode_bits = 9'h1FF; pending_ops.push_back(b);
    b.create = 0; pending_ops.push_back(b);
    b.queue_key = 32'h7FFFFFFF; b.create = 1; b.mode_bits = 0; pending_ops.push_back(b);
    b = plain(OP_SEND, 0); b.size = 0; pending_ops.push_back(b);
    b.size = 8193; pending_ops.push_back(b);
    b.size = 10; b.msg_type = 7; b.payload_handle = 32'hFFFFFFFF; pending_ops.push_back(b);
    b.msg_type = 32'h7FFFFFFF; b.caller_pid = 15'h7FFF; b.payload_handle = 1;
    pending_ops.push_back(b);
    b.msg_type = 32'h80000000; b.size = 8192; pending_ops.push_back(b);
    b.msg_type = 3; b.size = 1; pending_ops.push_back(b);
    b = plain(OP_RECEIVE, 0); b.msg_type = 7; b.size = 0; pending_ops.push_back(b);
    b.msg_type = -5; b.size = 16'hFFFF; b.caller_pid = 15'h7FFF; pending_ops.push_back(b);
    b.msg_type = 99; pending_ops.push_back(b);
    b.nowait = 0; pending_ops.push_back(b);
    b = plain(OP_SET, 0); b.new_limit = 5; b.mode_bits = 9'h1FF; pending_ops.push_back(b);
    b = plain(OP_SEND, 0); b.size = 10; pending_ops.push_back(b);
    b.nowait = 0; pending_ops.push_back(b);
    pending_ops.push_back(plain(OP_STAT, 0));
    b = plain(OP_RECEIVE, 0); b.msg_type = 32'h80000000; pending_ops.push_back(b);
    pending_ops.push_back(plain(OP_REMOVE, 0));
    pending_ops.push_back(plain(OP_RECEIVE, 0));
    pending_ops.push_back(plain(OP_STAT, 16));
    drain();

    write_reg(CFG_DEFAULT_LIMIT, 20'hFFFFF);
    write_reg(CFG_MAX_BYTES, 16'hFFFF);
    random_phase(550, 21, 62, 45);
    write_reg(CFG_DEFAULT_LIMIT, 0);
    write_reg(CFG_MAX_BYTES, 1);
    random_phase(500, 62, 21, 40);
    write_reg(CFG_DEFAULT_LIMIT, 300);
    write_reg(CFG_MAX_BYTES, 200);
    random_phase(550, 0, 0, 50);

    if (awaited_results.size() > 0) begin
      $error("%0d results never arrived", awaited_results.size());
      errors++;
    end
    $display("checked %0d results; ok %0d, full %0d, pool out %0d, empty %0d, too large %0d",
             results_seen, status_seen[ST_OK], status_seen[ST_FULL] + status_seen[ST_FULLWB],
             status_seen[ST_POOL], status_seen[ST_EMPTY] + status_seen[ST_EMPTYWB],
             status_seen[ST_TOOLARGE]);
    $display("configurations: reset values, widest limits, zero limit and one byte, mid values");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: typed_message_queue_engine.f
rtl/core/tmq_pkg.sv
rtl/core/tmq_ram.sv
rtl/core/tmq_cell.sv
rtl/core/typed_message_queue_engine.sv
rtl/core/tmq_checker.sv
test/tb.sv
